@@ src/ttpd_pkg.sv @@
// Shared constants, tables and channel widening functions for the tiled texture decoder.
package ttpd_pkg;

   // Default coordinate width of the block.
   localparam int COORD_BITS_DEFAULT = 10;

   // Fixed field widths.
   localparam int CSR_DATA_W = 23;
   localparam int CSR_INDEX_W = 2;
   localparam int BUF_W = 23;
   localparam int OFFSET_W = 22;
   localparam int STATUS_W = 2;
   localparam int FMT_W = 3;
   localparam int BPP_W = 3;
   localparam int MORTON_W = 6;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_SIZE = 2'd3;

   // Pixel format codes; codes above RGBA4 are invalid.
   localparam logic [FMT_W-1:0] FMT_RGBA8 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RGB8 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_RGB5A1 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGBA4 = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CONFIG = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

   // Morton interleave of the low three coordinate bits within a tile.
   localparam logic [MORTON_W-1:0] MORTON_X [8] = '{6'd0, 6'd1, 6'd4, 6'd5,
                                                    6'd16, 6'd17, 6'd20, 6'd21};
   localparam logic [MORTON_W-1:0] MORTON_Y [8] = '{6'd0, 6'd2, 6'd8, 6'd10,
                                                    6'd32, 6'd34, 6'd40, 6'd42};

   // Points at which floor(7*v/31) steps up, for v of five bits.
   localparam logic [4:0] W5_STEP [7] = '{5'd5, 5'd9, 5'd14, 5'd18, 5'd23, 5'd27, 5'd31};

   // Format information handed from the configuration block to the datapath.
   typedef struct packed {
      logic [FMT_W-1:0] format;
      logic [BPP_W-1:0] bpp;
      logic bad;
   } fmt_info_type;

   // Bytes per pixel of a format, zero for an invalid code.
   function automatic logic [BPP_W-1:0] format_bpp(input logic [FMT_W-1:0] fmt);
      logic [BPP_W-1:0] bpp;
      case (fmt)
         FMT_RGBA8: bpp = 3'd4;
         FMT_RGB8: bpp = 3'd3;
         FMT_RGB5A1: bpp = 3'd2;
         FMT_RGB565: bpp = 3'd2;
         FMT_RGBA4: bpp = 3'd2;
         default: bpp = 3'd0;
      endcase
      return bpp;
   endfunction

   // v*255/15 is exactly v*17, which is the nibble repeated.
   function automatic logic [7:0] widen4(input logic [3:0] v);
      return {v, v};
   endfunction

   // v*255/31 truncated: 255 = 8*31 + 7, so the result is 8*v plus floor(7*v/31).
   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [2:0] steps;
      steps = 3'd0;
      for (int i = 0; i < 7; i++) begin
         steps = steps + 3'(v >= W5_STEP[i]);
      end
      return {v, 3'b000} + {5'd0, steps};
   endfunction

   // v*255/63 truncated: 255 = 4*63 + 3, so the result is 4*v plus floor(v/21).
   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [1:0] steps;
      steps = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
      return {v, 2'b00} + {6'd0, steps};
   endfunction

endpackage

@@ src/ttpd_cfg.sv @@
// Configuration registers and the values derived from them: row stride and validity.
module ttpd_cfg import ttpd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output logic [COORD_BITS:0]     image_width,
   output logic [COORD_BITS:0]     image_height,
   output logic [COORD_BITS+7:0]   stride,
   output fmt_info_type            fmt_info
);

   localparam int DIM_W = COORD_BITS + 1;
   localparam int TILES_W = COORD_BITS - 1;
   localparam int CNT_W = 2 * TILES_W;
   localparam int STRIDE_W = COORD_BITS + 8;
   localparam int TOTAL_W = CNT_W + BPP_W + 6;
   localparam int CMP_W = (TOTAL_W > BUF_W) ? TOTAL_W : BUF_W;

   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [FMT_W-1:0] format_ff;
   logic [BUF_W-1:0] bufsize_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [STRIDE_W-1:0] stride_in;
   fmt_info_type info_ff;
   fmt_info_type info_in;

   logic [DIM_W:0] width_up;
   logic [DIM_W:0] height_up;
   logic [TILES_W-1:0] tiles_w;
   logic [TILES_W-1:0] tiles_h;
   logic [CNT_W-1:0] tile_cnt;
   logic [BPP_W-1:0] bpp;
   logic [CMP_W-1:0] total;

   // Register writes from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '0;
         height_ff <= '0;
         format_ff <= '0;
         bufsize_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: width_ff <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_PIXEL_FORMAT: format_ff <= csr_wdata[FMT_W-1:0];
            CSR_BUFFER_SIZE: bufsize_ff <= csr_wdata[BUF_W-1:0];
            default: ;
         endcase
      end
   end

   // Whole tiles across and down, with each row padded to a whole tile.
   always_comb begin
      width_up = {1'b0, width_ff} + (DIM_W+1)'(7);
      height_up = {1'b0, height_ff} + (DIM_W+1)'(7);
      tiles_w = width_up[DIM_W:3];
      tiles_h = height_up[DIM_W:3];
      bpp = format_bpp(format_ff);
      tile_cnt = CNT_W'(tiles_w) * CNT_W'(tiles_h);
      total = (CMP_W'(tile_cnt) * CMP_W'(bpp)) << 6;
      stride_in = (STRIDE_W'(tiles_w) * STRIDE_W'(bpp)) << 6;
      info_in.format = format_ff;
      info_in.bpp = bpp;
      info_in.bad = (width_ff == '0) || (height_ff == '0) || (format_ff > FMT_RGBA4) ||
                    (total > CMP_W'(bufsize_ff));
   end

   // Derived values are registered from the written registers and settle in the cycle after a write.
   always_ff @(posedge clock) begin
      if (reset) begin
         info_ff <= '{format: FMT_RGBA8, bpp: '0, bad: 1'b1};
         stride_ff <= '0;
      end else begin
         info_ff <= info_in;
         stride_ff <= stride_in;
      end
   end

   assign image_width = width_ff;
   assign image_height = height_ff;
   assign stride = stride_ff;
   assign fmt_info = info_ff;

endmodule

@@ src/ttpd_addr.sv @@
// Tiled byte offset of a pixel and its status.
module ttpd_addr import ttpd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic [COORD_BITS-1:0]  pixel_x,
   input  logic [COORD_BITS-1:0]  pixel_y,
   input  logic [COORD_BITS:0]    image_width,
   input  logic [COORD_BITS:0]    image_height,
   input  logic [COORD_BITS+7:0]  stride,
   input  fmt_info_type           fmt_info,
   output logic [OFFSET_W-1:0]    byte_offset,
   output logic [STATUS_W-1:0]    status
);

   localparam int TILE_W = COORD_BITS - 2;
   localparam int STRIDE_W = COORD_BITS + 8;
   localparam int FULL_W = TILE_W + STRIDE_W + 1;
   localparam int SUM_W = (FULL_W > OFFSET_W) ? FULL_W : OFFSET_W;

   logic [COORD_BITS:0] x_ext;
   logic [COORD_BITS:0] y_ext;
   logic [TILE_W-1:0] tile_x;
   logic [TILE_W-1:0] tile_y;
   logic [MORTON_W:0] morton;
   logic [SUM_W-1:0] row_part;
   logic [SUM_W-1:0] col_part;
   logic [SUM_W-1:0] sub_part;
   logic [SUM_W-1:0] sum;
   logic outside;

   // Tile row times stride, tile column times tile size, and the Morton place in the tile.
   always_comb begin
      x_ext = {1'b0, pixel_x};
      y_ext = {1'b0, pixel_y};
      tile_x = x_ext[COORD_BITS:3];
      tile_y = y_ext[COORD_BITS:3];
      morton = {1'b0, MORTON_X[pixel_x[2:0]]} + {1'b0, MORTON_Y[pixel_y[2:0]]};
      row_part = SUM_W'(tile_y) * SUM_W'(stride);
      col_part = (SUM_W'(tile_x) * SUM_W'(fmt_info.bpp)) << 6;
      sub_part = SUM_W'(morton) * SUM_W'(fmt_info.bpp);
      sum = row_part + col_part + sub_part;
      byte_offset = sum[OFFSET_W-1:0];
   end

   // A bad configuration takes precedence over a coordinate outside the image.
   always_comb begin
      outside = (x_ext >= image_width) || (y_ext >= image_height);
      if (fmt_info.bad) begin
         status = STATUS_BAD_CONFIG;
      end else if (outside) begin
         status = STATUS_OUTSIDE;
      end else begin
         status = STATUS_OK;
      end
   end

endmodule

@@ src/ttpd_color.sv @@
// Unpacks the raw little-endian pixel bytes into 8-bit red, green, blue and alpha.
module ttpd_color import ttpd_pkg::*; (
   input  logic [31:0]       raw_pixel,
   input  logic [FMT_W-1:0]  format,
   output logic [7:0]        red,
   output logic [7:0]        green,
   output logic [7:0]        blue,
   output logic [7:0]        alpha
);

   logic [15:0] px;

   // Channel placement by format; narrow channels are widened to eight bits.
   always_comb begin
      px = raw_pixel[15:0];
      alpha = 8'hFF;
      case (format)
         FMT_RGBA8: begin
            red = raw_pixel[31:24];
            green = raw_pixel[23:16];
            blue = raw_pixel[15:8];
            alpha = raw_pixel[7:0];
         end
         FMT_RGB8: begin
            red = raw_pixel[23:16];
            green = raw_pixel[15:8];
            blue = raw_pixel[7:0];
         end
         FMT_RGB5A1: begin
            red = widen5(px[15:11]);
            green = widen5(px[10:6]);
            blue = widen5(px[5:1]);
            alpha = px[0] ? 8'hFF : 8'h00;
         end
         FMT_RGB565: begin
            red = widen5(px[15:11]);
            green = widen6(px[10:5]);
            blue = widen5(px[4:0]);
         end
         default: begin
            red = widen4(px[15:12]);
            green = widen4(px[11:8]);
            blue = widen4(px[7:4]);
            alpha = widen4(px[3:0]);
         end
      endcase
   end

endmodule

@@ src/tiled_texture_pixel_decode.sv @@
// Top level of the tiled texture pixel decoder: handshakes, request and result registers.
//
// Each request carries a pixel coordinate and the raw bytes found at it, and yields one
// result: the pixel's byte offset in an 8x8 Morton-tiled buffer, its colour widened to
// eight bits a channel, and a status. The block takes one request every clock cycle while
// its result side does not stall; a request is held in the request register, and its
// result is then registered in the result register, which presents it, with the offset
// multiply of tile row by row stride as the longest path between the two registers.
// While the result side stalls the block holds two requests, one in each register, and
// then stalls its request side. Configuration writes take effect on the registers at
// once, and the derived row stride and validity flag settle in the cycle after the write.
module tiled_texture_pixel_decode import ttpd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COORD_BITS-1:0]   req_pixel_x,
   input  logic [COORD_BITS-1:0]   req_pixel_y,
   input  logic [31:0]             req_raw_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OFFSET_W-1:0]     rsp_byte_offset,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   output logic [7:0]              rsp_alpha,
   output logic [STATUS_W-1:0]     rsp_status
);

   logic [COORD_BITS:0] image_width;
   logic [COORD_BITS:0] image_height;
   logic [COORD_BITS+7:0] stride;
   fmt_info_type fmt_info;

   logic req_valid_ff;
   logic req_valid_in;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic [31:0] raw_ff;

   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [OFFSET_W-1:0] offset_ff;
   logic [OFFSET_W-1:0] offset_in;
   logic [7:0] red_ff;
   logic [7:0] red_in;
   logic [7:0] green_ff;
   logic [7:0] green_in;
   logic [7:0] blue_ff;
   logic [7:0] blue_in;
   logic [7:0] alpha_ff;
   logic [7:0] alpha_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;

   logic [OFFSET_W-1:0] calc_offset;
   logic [STATUS_W-1:0] calc_status;
   logic [7:0] calc_red;
   logic [7:0] calc_green;
   logic [7:0] calc_blue;
   logic [7:0] calc_alpha;
   logic out_free;
   logic req_take;

   ttpd_cfg #(
      .COORD_BITS(COORD_BITS)
   ) u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .image_width(image_width),
      .image_height(image_height),
      .stride(stride),
      .fmt_info(fmt_info)
   );

   ttpd_addr #(
      .COORD_BITS(COORD_BITS)
   ) u_addr (
      .pixel_x(x_ff),
      .pixel_y(y_ff),
      .image_width(image_width),
      .image_height(image_height),
      .stride(stride),
      .fmt_info(fmt_info),
      .byte_offset(calc_offset),
      .status(calc_status)
   );

   ttpd_color u_color (
      .raw_pixel(raw_ff),
      .format(fmt_info.format),
      .red(calc_red),
      .green(calc_green),
      .blue(calc_blue),
      .alpha(calc_alpha)
   );

   // Flow control: the result register frees when empty or taken, the request
   // register then moves on and can take a new request in the same cycle.
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      req_stall = req_valid_ff && !out_free;
      req_take = req_valid && !req_stall;
      req_valid_in = req_stall ? req_valid_ff : req_valid;
      rsp_valid_in = out_free ? req_valid_ff : rsp_valid_ff;
   end

   // Error results carry zero in every field but the status.
   always_comb begin
      status_in = calc_status;
      if (calc_status == STATUS_OK) begin
         offset_in = calc_offset;
         red_in = calc_red;
         green_in = calc_green;
         blue_in = calc_blue;
         alpha_in = calc_alpha;
      end else begin
         offset_in = '0;
         red_in = '0;
         green_in = '0;
         blue_in = '0;
         alpha_in = '0;
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff <= req_pixel_x;
         y_ff <= req_pixel_y;
         raw_ff <= req_raw_pixel;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (out_free && req_valid_ff) begin
         offset_ff <= offset_in;
         red_ff <= red_in;
         green_ff <= green_in;
         blue_ff <= blue_in;
         alpha_ff <= alpha_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_red = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue = blue_ff;
   assign rsp_alpha = alpha_ff;
   assign rsp_status = status_ff;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the tiled texture pixel decoder.
`timescale 1ns / 1ps

module tb import ttpd_pkg::*; ();

   localparam logic [BUF_W-1:0] BUFFER_MAX = 23'h7F_FFFF;
   localparam int HOLD_CYCLES = 80;
   localparam int PRINT_LIMIT = 40;

   // One decoded pixel as it leaves the block.
   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic [7:0]          alpha;
      logic [STATUS_W-1:0] status;
   } decoded_pixel_type;

   // Holds a copy of the configuration and the queue of decoded pixels still owed.
   class pixel_scoreboard_type;
      logic [10:0]         image_width;
      logic [10:0]         image_height;
      logic [FMT_W-1:0]    image_format;
      logic [BUF_W-1:0]    buffer_bytes;
      decoded_pixel_type   owed_pixels[$];
      int                  mismatches;
      int                  results_seen;

      function new();
         image_width = '0;
         image_height = '0;
         image_format = '0;
         buffer_bytes = '0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      task report_mismatch(input string what);
         if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
         end
         mismatches++;
      endtask

      function void set_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_IMAGE_WIDTH: image_width = data[10:0];
            CSR_IMAGE_HEIGHT: image_height = data[10:0];
            CSR_PIXEL_FORMAT: image_format = data[FMT_W-1:0];
            default: buffer_bytes = data;
         endcase
      endfunction

      function int unsigned format_bytes(input logic [FMT_W-1:0] fmt);
         case (fmt)
            FMT_RGBA8: return 4;
            FMT_RGB8: return 3;
            FMT_RGB5A1, FMT_RGB565, FMT_RGBA4: return 2;
            default: return 0;
         endcase
      endfunction

      // Bytes taken by the image once both sides are padded up to whole tiles.
      function int unsigned padded_bytes(input int unsigned w, input int unsigned h,
                                         input logic [FMT_W-1:0] fmt);
         return ((w + 7) >> 3) * ((h + 7) >> 3) * 64 * format_bytes(fmt);
      endfunction

      // Scales a channel of the given width up to eight bits, truncating.
      function logic [7:0] widen(input int unsigned v, input int unsigned bits);
         int unsigned maxv;
         maxv = (1 << bits) - 1;
         return 8'(((v & maxv) * 255) / maxv);
      endfunction

      function decoded_pixel_type decode_pixel(input logic [9:0] x, input logic [9:0] y,
                                               input logic [31:0] raw);
         decoded_pixel_type res;
         int unsigned bpp, xi, yi, stride, offset;
         logic [15:0] px;
         logic [5:0] morton;
         res = '0;
         px = raw[15:0];
         xi = x;
         yi = y;
         bpp = format_bytes(image_format);
         if (image_width == 0 || image_height == 0 || bpp == 0) begin
            res.status = STATUS_BAD_CONFIG;
         end else if (padded_bytes(image_width, image_height, image_format) >
                      buffer_bytes) begin
            res.status = STATUS_BAD_CONFIG;
         end else if (xi >= image_width || yi >= image_height) begin
            res.status = STATUS_OUTSIDE;
         end else begin
            // Z order within the tile: x in the even bits, y in the odd bits.
            morton = {y[2], x[2], y[1], x[1], y[0], x[0]};
            stride = ((image_width + 7) >> 3) * 64 * bpp;
            offset = (yi >> 3) * stride + (xi >> 3) * 64 * bpp + morton * bpp;
            res.byte_offset = OFFSET_W'(offset);
            res.status = STATUS_OK;
            res.alpha = 8'd255;
            case (image_format)
               FMT_RGBA8: begin
                  {res.red, res.green, res.blue, res.alpha} = raw;
               end
               FMT_RGB8: begin
                  {res.red, res.green, res.blue} = raw[23:0];
               end
               FMT_RGB5A1: begin
                  res.red = widen(px[15:11], 5);
                  res.green = widen(px[10:6], 5);
                  res.blue = widen(px[5:1], 5);
                  res.alpha = px[0] ? 8'd255 : 8'd0;
               end
               FMT_RGB565: begin
                  res.red = widen(px[15:11], 5);
                  res.green = widen(px[10:5], 6);
                  res.blue = widen(px[4:0], 5);
               end
               default: begin
                  res.red = widen(px[15:12], 4);
                  res.green = widen(px[11:8], 4);
                  res.blue = widen(px[7:4], 4);
                  res.alpha = widen(px[3:0], 4);
               end
            endcase
         end
         return res;
      endfunction

      function void note_request(input logic [9:0] x, input logic [9:0] y,
                                 input logic [31:0] raw);
         owed_pixels.insert(owed_pixels.size(), decode_pixel(x, y, raw));
      endfunction

      task check_result(input decoded_pixel_type got);
         decoded_pixel_type want;
         results_seen++;
         if (owed_pixels.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no request waiting",
                                      results_seen));
            return;
         end
         want = owed_pixels.pop_front();
         if (got.byte_offset !== want.byte_offset)
            report_mismatch($sformatf("result %0d byte_offset %0h, expected %0h",
                                      results_seen, got.byte_offset, want.byte_offset));
         if (got.red !== want.red)
            report_mismatch($sformatf("result %0d red %0h, expected %0h",
                                      results_seen, got.red, want.red));
         if (got.green !== want.green)
            report_mismatch($sformatf("result %0d green %0h, expected %0h",
                                      results_seen, got.green, want.green));
         if (got.blue !== want.blue)
            report_mismatch($sformatf("result %0d blue %0h, expected %0h",
                                      results_seen, got.blue, want.blue));
         if (got.alpha !== want.alpha)
            report_mismatch($sformatf("result %0d alpha %0h, expected %0h",
                                      results_seen, got.alpha, want.alpha));
         if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_seen, got.status, want.status));
      endtask

      task check_leftover();
         if (owed_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_pixels.size()));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_stall;
   logic [9:0]             req_pixel_x;
   logic [9:0]             req_pixel_y;
   logic [31:0]            req_raw_pixel;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [OFFSET_W-1:0]    rsp_byte_offset;
   logic [7:0]             rsp_red;
   logic [7:0]             rsp_green;
   logic [7:0]             rsp_blue;
   logic [7:0]             rsp_alpha;
   logic [STATUS_W-1:0]    rsp_status;

   pixel_scoreboard_type scoreboard = new();
   bit long_hold_pending = 1'b0;
   int requests_sent = 0;
   int burst_left = 0;

   tiled_texture_pixel_decode u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_raw_pixel   (req_raw_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every accepted result is checked against the oldest owed pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         scoreboard.check_result({rsp_byte_offset, rsp_red, rsp_green, rsp_blue,
                                  rsp_alpha, rsp_status});
      end
   end

   // The result side stalls in stretches of differing density, with an
   // occasional long hold-off so that the block backs up into its request side.
   initial begin : result_stall_pattern
      int mode, stretch;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         stretch = $urandom_range(8, 60);
         repeat (stretch) begin
            @(negedge clock);
            if (long_hold_pending) begin
               long_hold_pending = 1'b0;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      scoreboard.set_register(index, data);
      @(negedge clock);
   endtask

   // Writes all four registers, then lets the derived stride and flag settle.
   task automatic apply_config(input logic [CSR_DATA_W-1:0] w_data,
                               input logic [CSR_DATA_W-1:0] h_data,
                               input logic [CSR_DATA_W-1:0] fmt_data,
                               input logic [CSR_DATA_W-1:0] buf_data);
      write_register(CSR_IMAGE_WIDTH, w_data);
      write_register(CSR_IMAGE_HEIGHT, h_data);
      write_register(CSR_PIXEL_FORMAT, fmt_data);
      write_register(CSR_BUFFER_SIZE, buf_data);
      csr_write <= 1'b0;
      repeat (2) @(negedge clock);
   endtask

   // Offers one request in bursts with random gaps, and waits for its acceptance.
   task automatic offer_pixel(input logic [9:0] x, input logic [9:0] y,
                              input logic [31:0] raw);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      req_raw_pixel <= raw;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      scoreboard.note_request(x, y, raw);
      requests_sent++;
      @(negedge clock);
   endtask

   // The sender pauses until every owed pixel has come back.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (scoreboard.owed_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Sometimes sets the unused upper bits of a register write.
   function automatic logic [CSR_DATA_W-1:0] with_noise(input int unsigned value,
                                                         input int unsigned bits);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'(value);
      if ($urandom_range(0, 3) == 0)
         data = data | (CSR_DATA_W'($urandom) << bits);
      return data;
   endfunction

   // Mostly inside the image, sometimes on its edge, sometimes anywhere.
   function automatic logic [9:0] pick_coord(input int unsigned limit);
      int unsigned top, sel;
      sel = $urandom_range(0, 9);
      top = (limit > 1024) ? 1024 : limit;
      if (limit == 0 || sel == 0) return 10'($urandom);
      if (sel == 1) return (top > 1023) ? 10'd1023 : 10'(top);
      if (sel == 2) return 10'(top - 1);
      return 10'($urandom_range(0, top - 1));
   endfunction

   // One setting of the registers followed by a run of requests against it.
   task automatic random_phase(input bit force_hold);
      int unsigned w, h, need, buf_bytes, kind, count;
      logic [FMT_W-1:0] fmt;
      kind = $urandom_range(0, 9);
      w = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1024);
      h = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1024);
      fmt = FMT_W'($urandom_range(FMT_RGBA8, FMT_RGBA4));
      need = scoreboard.padded_bytes(w, h, fmt);
      buf_bytes = need + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 4096));
      case (kind)
         6: buf_bytes = need - $urandom_range(1, 64);
         7: begin
            case ($urandom_range(0, 2))
               0: fmt = FMT_W'($urandom_range(FMT_RGBA4 + 1, 7));
               1: w = 0;
               default: h = 0;
            endcase
         end
         8: begin
            w = $urandom_range(0, 1) ? 1 : 1024;
            h = $urandom_range(0, 1) ? 1 : 1024;
            need = scoreboard.padded_bytes(w, h, fmt);
            buf_bytes = $urandom_range(0, 1) ? need : BUFFER_MAX;
         end
         9: begin
            // Widths beyond the stated range push the offset past 22 bits.
            w = $urandom_range(1025, 2047);
            h = $urandom_range(520, 1016);
            buf_bytes = BUFFER_MAX;
         end
         default: ;
      endcase
      if (buf_bytes > BUFFER_MAX) buf_bytes = BUFFER_MAX;
      if (kind == 5) buf_bytes = $urandom_range(0, BUFFER_MAX);
      apply_config(with_noise(w, 11), with_noise(h, 11), with_noise(fmt, FMT_W),
                   CSR_DATA_W'(buf_bytes));
      if (force_hold || $urandom_range(0, 5) == 0) long_hold_pending = 1'b1;
      count = $urandom_range(40, 90);
      repeat (count) offer_pixel(pick_coord(w), pick_coord(h), $urandom);
      drain();
   endtask

   initial begin : stimulus
      int unsigned need;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      req_raw_pixel = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Registers still at their reset values: every request is bad configuration.
      offer_pixel(10'd0, 10'd0, 32'h0000_0000);
      offer_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF);
      drain();

      // Largest image in the widest format, with the buffer exactly large enough.
      apply_config(23'd1024, 23'd1024, CSR_DATA_W'(FMT_RGBA8),
                   CSR_DATA_W'(scoreboard.padded_bytes(1024, 1024, FMT_RGBA8)));
      offer_pixel(10'd0, 10'd0, 32'h0000_0000);
      offer_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF);
      offer_pixel(10'd7, 10'd7, 32'h1234_5678);
      offer_pixel(10'd1023, 10'd0, 32'hA5A5_5A5A);
      offer_pixel(10'd0, 10'd1023, 32'h0F0F_F0F0);
      offer_pixel(10'd9, 10'd10, 32'hDEAD_BEEF);
      drain();

      // Each of the narrower formats, all channels at full scale and then random.
      for (int f = FMT_RGB8; f <= FMT_RGBA4; f++) begin
         apply_config(23'd1024, 23'd1024, CSR_DATA_W'(f), BUFFER_MAX);
         offer_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF);
         offer_pixel(10'd5, 10'd3, $urandom);
         drain();
      end

      // Coordinates just outside the image, and the last pixel inside it.
      need = scoreboard.padded_bytes(100, 50, FMT_RGB565);
      apply_config(23'd100, 23'd50, CSR_DATA_W'(FMT_RGB565), CSR_DATA_W'(need));
      offer_pixel(10'd100, 10'd0, $urandom);
      offer_pixel(10'd0, 10'd50, $urandom);
      offer_pixel(10'd99, 10'd49, $urandom);
      drain();

      // Buffer one byte short of the padded tiles.
      apply_config(23'd100, 23'd50, CSR_DATA_W'(FMT_RGB565), CSR_DATA_W'(need - 1));
      offer_pixel(10'd0, 10'd0, $urandom);
      drain();

      // Unknown format, then zero width, then zero height.
      apply_config(23'd16, 23'd16, CSR_DATA_W'(FMT_RGBA4 + 3'd1), BUFFER_MAX);
      offer_pixel(10'd1, 10'd1, $urandom);
      drain();
      apply_config(23'd0, 23'd16, CSR_DATA_W'(FMT_RGBA8), BUFFER_MAX);
      offer_pixel(10'd0, 10'd0, $urandom);
      drain();
      apply_config(23'd16, 23'd0, CSR_DATA_W'(FMT_RGBA8), BUFFER_MAX);
      offer_pixel(10'd0, 10'd0, $urandom);
      drain();

      // Over-wide image whose offset wraps at 22 bits.
      apply_config(23'd2047, 23'd1016, CSR_DATA_W'(FMT_RGBA8), BUFFER_MAX);
      offer_pixel(10'd1023, 10'd1015, $urandom);
      drain();

      // Random settings, the first of them under a long result hold-off.
      random_phase(1'b1);
      while (requests_sent < 1400) random_phase(1'b0);

      drain();
      repeat (8) @(negedge clock);
      scoreboard.check_leftover();
      if (scoreboard.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ tiled_texture_pixel_decode.f @@
src/ttpd_pkg.sv
src/ttpd_cfg.sv
src/ttpd_addr.sv
src/ttpd_color.sv
src/tiled_texture_pixel_decode.sv
verif/tb.sv
